// ----- hw/rtl/cstc_pkg.sv -----
// ----------------------------------------------------------------------------
// cstc_pkg
// Shared types and constants for the class-sorted table with cursor.
// ----------------------------------------------------------------------------
package cstc_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int ID_BITS     = 16;
  localparam int CLASS_BITS  = 4;

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  localparam logic [2:0] ACT_ADD   = 3'd0;
  localparam logic [2:0] ACT_DEL   = 3'd1;
  localparam logic [2:0] ACT_FIRST = 3'd2;
  localparam logic [2:0] ACT_NEXT  = 3'd3;
  localparam logic [2:0] ACT_FIND  = 3'd4;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_NONE = 2'd1;
  localparam logic [1:0] ST_DUP  = 2'd2;
  localparam logic [1:0] ST_FULL = 2'd3;

  typedef struct packed {
    logic [ID_BITS-1:0]    id;
    logic [CLASS_BITS-1:0] cls;
  } entry_t;

  typedef struct packed {
    logic id_eq;
    logic cls_le;
  } cmp_t;

endpackage

// ----- hw/rtl/cstc_ram.sv -----
// ----------------------------------------------------------------------------
// cstc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cstc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/cstc_cmp.sv -----
// ----------------------------------------------------------------------------
// cstc_cmp
// Shared compare unit: id equality and class order of one stored entry
// against the key of the current command.
// ----------------------------------------------------------------------------
module cstc_cmp
  import cstc_pkg::*;
(
  input  entry_t entry,
  input  entry_t key,
  output cmp_t   res
);

  always_comb begin
    res.id_eq  = (entry.id == key.id);
    res.cls_le = (entry.cls <= key.cls);
  end

endmodule

// ----- hw/rtl/class_sorted_table_with_cursor_top.sv -----
// ----------------------------------------------------------------------------
// class_sorted_table_with_cursor_top
// Table of (id, class) entries kept in class order, with a cursor. Commands
// are taken on start while busy is low; one result per command is shown for
// one cycle with done high and cannot be held off. The entries sit in one
// single-port-read RAM; every scan, shift or delete steps through it one
// entry a cycle, the scan through the shared compare unit, so the cost is
// set by that read port: add (scan, then shift) grows with count, find with
// the entries scanned, delete with count - cursor; move first, move next and
// unused codes do not step through the table. An add to a full table is
// rejected only after the whole scan.
// ----------------------------------------------------------------------------
module class_sorted_table_with_cursor_top
  import cstc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [2:0]            action,
  input  logic [ID_BITS-1:0]    item_id,
  input  logic [CLASS_BITS-1:0] item_class,
  output logic                  done,
  output logic [1:0]            status,
  output logic [ID_BITS-1:0]    out_id,
  output logic [CLASS_BITS-1:0] out_class
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_SHIFT = 3'd2;
  localparam logic [2:0] S_WRITE = 3'd3;
  localparam logic [2:0] S_DEL   = 3'd4;
  localparam logic [2:0] S_FETCH = 3'd5;
  localparam logic [2:0] S_GET   = 3'd6;

  logic [2:0]       state;
  logic [2:0]       act;
  entry_t           key;
  logic [CNT_W-1:0] count;
  logic [IDX_W-1:0] cur_idx;
  logic             cur_valid;
  logic [CNT_W-1:0] ptr;
  logic [IDX_W-1:0] pidx;
  logic             pend;
  logic [CNT_W-1:0] pos;
  logic             found;
  entry_t           res;

  logic             issue;
  logic             we;
  logic [IDX_W-1:0] waddr;
  entry_t           wdata;
  logic [IDX_W-1:0] raddr;
  entry_t           rdata;
  cmp_t             cmp;

  cstc_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(TABLE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  cstc_cmp u_cmp (
    .entry(rdata),
    .key  (key),
    .res  (cmp)
  );

  assign busy      = (state != S_IDLE);
  assign out_id    = (status == ST_OK) ? res.id : '0;
  assign out_class = (status == ST_OK) ? res.cls : '0;

  // ram port control
  always_comb begin
    issue = 1'b0;
    we    = 1'b0;
    raddr = ptr[IDX_W-1:0];
    waddr = '0;
    wdata = rdata;
    case (state)
      S_SCAN: begin
        issue = (ptr < count);
      end
      S_SHIFT: begin
        issue = (ptr > pos);
        raddr = IDX_W'(ptr - CNT_W'(1));
        we    = pend;
        waddr = pidx;
      end
      S_DEL: begin
        issue = (ptr < count);
        we    = pend && (pidx != cur_idx);
        waddr = pidx - IDX_W'(1);
      end
      S_WRITE: begin
        we    = 1'b1;
        waddr = pos[IDX_W-1:0];
        wdata = key;
      end
      default: begin
        issue = 1'b0;
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      cur_idx   <= '0;
      cur_valid <= 1'b0;
      pend      <= 1'b0;
      found     <= 1'b0;
      done      <= 1'b0;
      status    <= ST_NONE;
    end else begin
      done <= 1'b0;
      pend <= issue;
      case (state)
        S_IDLE: begin
          if (start) begin
            act   <= action;
            key   <= '{id: item_id, cls: item_class};
            found <= 1'b0;
            case (action)
              ACT_ADD, ACT_FIND: begin
                ptr   <= '0;
                state <= S_SCAN;
              end
              ACT_DEL: begin
                if (cur_valid) begin
                  ptr   <= CNT_W'(cur_idx);
                  state <= S_DEL;
                end else begin
                  status <= ST_NONE;
                  done   <= 1'b1;
                end
              end
              ACT_FIRST: begin
                if (count == '0) begin
                  cur_valid <= 1'b0;
                  cur_idx   <= '0;
                  status    <= ST_NONE;
                  done      <= 1'b1;
                end else begin
                  ptr       <= '0;
                  cur_valid <= 1'b1;
                  cur_idx   <= '0;
                  state     <= S_FETCH;
                end
              end
              ACT_NEXT: begin
                if (!cur_valid || (CNT_W'(cur_idx) + CNT_W'(1)) >= count) begin
                  cur_valid <= 1'b0;
                  cur_idx   <= '0;
                  status    <= ST_NONE;
                  done      <= 1'b1;
                end else begin
                  ptr     <= CNT_W'(cur_idx) + CNT_W'(1);
                  cur_idx <= cur_idx + IDX_W'(1);
                  state   <= S_FETCH;
                end
              end
              default: begin
                status <= ST_NONE;
                done   <= 1'b1;
              end
            endcase
          end
        end
        S_FETCH: begin
          state <= S_GET;
        end
        S_GET: begin
          res    <= rdata;
          status <= ST_OK;
          done   <= 1'b1;
          state  <= S_IDLE;
        end
        S_SCAN: begin
          if (issue) begin
            ptr  <= ptr + CNT_W'(1);
            pidx <= ptr[IDX_W-1:0];
          end
          if (pend) begin
            if (cmp.id_eq) begin
              if (act == ACT_FIND) begin
                res       <= rdata;
                status    <= ST_OK;
                cur_valid <= 1'b1;
                cur_idx   <= pidx;
              end else begin
                status <= ST_DUP;
              end
              done  <= 1'b1;
              state <= S_IDLE;
            end else if (!found && !cmp.cls_le) begin
              found <= 1'b1;
              pos   <= CNT_W'(pidx);
            end
          end else if (!issue) begin
            if (act == ACT_FIND) begin
              cur_valid <= 1'b0;
              cur_idx   <= '0;
              status    <= ST_NONE;
              done      <= 1'b1;
              state     <= S_IDLE;
            end else if (count == CNT_W'(TABLE_DEPTH)) begin
              status <= ST_FULL;
              done   <= 1'b1;
              state  <= S_IDLE;
            end else begin
              if (!found) begin
                pos <= count;
              end
              ptr   <= count;
              state <= S_SHIFT;
            end
          end
        end
        S_SHIFT: begin
          if (issue) begin
            ptr  <= ptr - CNT_W'(1);
            pidx <= ptr[IDX_W-1:0];
          end
          if (!issue && !pend) begin
            state <= S_WRITE;
          end
        end
        S_WRITE: begin
          count <= count + CNT_W'(1);
          if (cur_valid && CNT_W'(cur_idx) >= pos) begin
            cur_idx <= cur_idx + IDX_W'(1);
          end
          res    <= key;
          status <= ST_OK;
          done   <= 1'b1;
          state  <= S_IDLE;
        end
        S_DEL: begin
          if (issue) begin
            ptr  <= ptr + CNT_W'(1);
            pidx <= ptr[IDX_W-1:0];
          end
          if (pend && (pidx == cur_idx)) begin
            res <= rdata;
          end
          if (!issue && !pend) begin
            count <= count - CNT_W'(1);
            if ((CNT_W'(cur_idx) + CNT_W'(1)) >= count) begin
              cur_valid <= 1'b0;
              cur_idx   <= '0;
            end
            status <= ST_OK;
            done   <= 1'b1;
            state  <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_cursor_in_table: assert property (@(posedge clk) disable iff (rst)
    cur_valid |-> (CNT_W'(cur_idx) < count))
    else $error("cursor points past the last entry");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(TABLE_DEPTH))
    else $error("entry count above table depth");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> (state == S_IDLE))
    else $error("result shown while sequencer still running");

  a_start_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("command transfer dropped without result");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (done && (status == ST_FULL)) |-> (count == CNT_W'(TABLE_DEPTH)))
    else $error("table full reported with free slots");

endmodule
